### hdl/tsat_pkg.sv
// ----------------------------------------------------------------------------
// Two-SAT solver package
// Field widths and the packed clause word shared by the solver files.
// ----------------------------------------------------------------------------
package tsat_pkg;

    localparam int MAX_VARS = 64;
    localparam int VAR_W    = 7;
    localparam int KIND_W   = 2;
    localparam int CLAUSE_W = 16;
    localparam int CNT_W    = 7;
    localparam int MASK_W   = MAX_VARS;
    localparam int OUT_W    = CNT_W + MASK_W + 1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VAR_W-1:0]  var_b;
        logic [VAR_W-1:0]  var_a;
    } clause_t;

endpackage

### hdl/tsat_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tsat_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/two_sat_scc_solver.sv
// ----------------------------------------------------------------------------
// Two-SAT solver
// Loads two-variable clauses and solves them by two depth-first passes.
// ----------------------------------------------------------------------------
// Clauses arrive one item per cycle on the s_ channel while the block is
// loading; s_tlast marks the last clause of a problem and starts the solve.
// s_tready is high only while the block is loading. cfg_wr_en writes num_vars;
// the user must use it only between problems; the block does not enforce this.
// The solve walks stored clauses through the clause memory read port: with C
// clauses each visited literal scans 2*C edge positions. After the two passes
// the result is formed from the truth mark of each variable in turn. One
// result item is then offered on the m_ channel and held until m_tready;
// while it waits no clause is accepted.
// After the result is taken the clause count, error flag and literal marks are
// cleared and loading resumes. Reset empties the problem and sets num_vars
// to one; the clause, finish and stack memories need no clearing.
// ----------------------------------------------------------------------------
module two_sat_scc_solver
    import tsat_pkg::*;
#(
    parameter int MAX_CLAUSES = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [VAR_W-1:0]    cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [CLAUSE_W-1:0] s_tdata,   // var_a, var_b, clause_kind
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata    // chosen_count, chosen_mask, input_error
);

    localparam int LW  = $clog2(2 * MAX_VARS + 1);
    localparam int SAW = $clog2(2 * MAX_VARS);
    localparam int NL  = 2 * MAX_VARS;
    localparam int CW  = $clog2(MAX_CLAUSES + 1);
    localparam int AW  = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
    localparam int EW  = CW + 1;
    localparam int SW  = LW + EW;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ROOT, ST_SCAN, ST_EVAL, ST_POP, ST_BNEXT, ST_BGOT, ST_OUT, ST_SEND
    } state_t;

    state_t            state_reg, state_next;
    logic [VAR_W-1:0]  nv_reg;
    logic [CW-1:0]     total_reg, total_next;
    logic              err_reg, err_next;
    logic [NL-1:0]     vis_reg, vis_next;
    logic [NL-1:0]     tru_reg, tru_next;
    logic [LW-1:0]     flen_reg, flen_next;
    logic [LW-1:0]     sp_reg, sp_next;
    logic [LW-1:0]     node_reg, node_next;
    logic [EW-1:0]     edge_reg, edge_next;
    logic [LW-1:0]     root_reg, root_next;
    logic [LW-1:0]     bidx_reg, bidx_next;
    logic              pass_reg, pass_next;
    logic [VAR_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MASK_W-1:0] mask_reg, mask_next;

    logic [VAR_W-1:0]  n_eff;
    logic [LW-1:0]     n_l, two_n;
    logic [VAR_W:0]    two_n_w;
    clause_t           in_cl;
    logic              in_ok;

    logic              cl_we, fin_we, stk_we;
    logic [CLAUSE_W-1:0] cl_rdata;
    logic [LW-1:0]     fin_rdata;
    logic [SW-1:0]     stk_rdata, stk_wdata;

    function automatic logic [LW-1:0] neg_lit(input logic [LW-1:0] l,
                                              input logic [LW-1:0] nn);
        return (l > nn) ? l - nn : l + nn;
    endfunction

    function automatic logic [SAW-1:0] lidx(input logic [LW-1:0] l);
        return SAW'(l - 1'b1);
    endfunction

    assign n_eff   = (nv_reg == '0) ? VAR_W'(1) :
                     (nv_reg > VAR_W'(MAX_VARS)) ? VAR_W'(MAX_VARS) : nv_reg;
    assign n_l     = LW'(n_eff);
    assign two_n_w = {n_eff, 1'b0};
    assign two_n   = LW'(two_n_w);
    assign in_cl   = clause_t'(s_tdata);
    assign in_ok   = (in_cl.var_a != '0) && (in_cl.var_a <= n_eff) &&
                     (in_cl.var_b != '0) && (in_cl.var_b <= n_eff) &&
                     (total_reg < CW'(MAX_CLAUSES));

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_SEND);
    assign m_tdata   = {err_reg, mask_reg, cnt_reg};
    assign stk_wdata = {node_reg, edge_reg + 1'b1};

    tsat_ram #(.WIDTH(CLAUSE_W), .DEPTH(MAX_CLAUSES)) u_clause_ram (
        .aclk  (aclk),
        .we    (cl_we),
        .waddr (total_reg[AW-1:0]),
        .wdata (s_tdata),
        .raddr (edge_reg[AW:1]),
        .rdata (cl_rdata)
    );

    tsat_ram #(.WIDTH(LW), .DEPTH(NL)) u_finish_ram (
        .aclk  (aclk),
        .we    (fin_we),
        .waddr (flen_reg[SAW-1:0]),
        .wdata (node_reg),
        .raddr (SAW'(bidx_reg - 1'b1)),
        .rdata (fin_rdata)
    );

    tsat_ram #(.WIDTH(SW), .DEPTH(NL)) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (sp_reg[SAW-1:0]),
        .wdata (stk_wdata),
        .raddr (SAW'(sp_reg - 1'b1)),
        .rdata (stk_rdata)
    );

    always_comb begin
        clause_t         rc;
        logic            cvalid;
        logic [LW-1:0]   x, y, from_l, to_l, v, c;
        rc         = clause_t'(cl_rdata);
        cvalid     = (rc.var_a != '0) && (rc.var_a <= n_eff) &&
                     (rc.var_b != '0) && (rc.var_b <= n_eff);
        x          = rc.kind[1] ? neg_lit(LW'(rc.var_a), n_l) : LW'(rc.var_a);
        y          = rc.kind[0] ? neg_lit(LW'(rc.var_b), n_l) : LW'(rc.var_b);
        if (!pass_reg) begin
            from_l = edge_reg[0] ? neg_lit(y, n_l) : neg_lit(x, n_l);
            to_l   = edge_reg[0] ? x : y;
        end else begin
            from_l = edge_reg[0] ? y : x;
            to_l   = edge_reg[0] ? neg_lit(x, n_l) : neg_lit(y, n_l);
        end
        v          = fin_rdata;
        c          = neg_lit(fin_rdata, n_l);
        state_next = state_reg;
        total_next = total_reg;
        err_next   = err_reg;
        vis_next   = vis_reg;
        tru_next   = tru_reg;
        flen_next  = flen_reg;
        sp_next    = sp_reg;
        node_next  = node_reg;
        edge_next  = edge_reg;
        root_next  = root_reg;
        bidx_next  = bidx_reg;
        pass_next  = pass_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        mask_next  = mask_reg;
        cl_we      = 1'b0;
        fin_we     = 1'b0;
        stk_we     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_ok) begin
                        cl_we      = 1'b1;
                        total_next = total_reg + 1'b1;
                    end else begin
                        err_next = 1'b1;
                    end
                    if (s_tlast) begin
                        root_next  = LW'(1);
                        pass_next  = 1'b0;
                        flen_next  = '0;
                        state_next = ST_ROOT;
                    end
                end
            end
            ST_ROOT: begin
                if (root_reg > two_n) begin
                    vis_next   = '0;
                    bidx_next  = flen_reg;
                    pass_next  = 1'b1;
                    state_next = ST_BNEXT;
                end else if (vis_reg[lidx(root_reg)]) begin
                    root_next = root_reg + 1'b1;
                end else begin
                    vis_next[lidx(root_reg)] = 1'b1;
                    node_next  = root_reg;
                    edge_next  = '0;
                    sp_next    = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (edge_reg >= {total_reg, 1'b0}) begin
                    if (!pass_reg) begin
                        fin_we    = 1'b1;
                        flen_next = flen_reg + 1'b1;
                    end
                    if (sp_reg == '0) begin
                        if (!pass_reg) begin
                            root_next  = root_reg + 1'b1;
                            state_next = ST_ROOT;
                        end else begin
                            bidx_next  = bidx_reg - 1'b1;
                            state_next = ST_BNEXT;
                        end
                    end else begin
                        sp_next    = sp_reg - 1'b1;
                        state_next = ST_POP;
                    end
                end else begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                edge_next  = edge_reg + 1'b1;
                state_next = ST_SCAN;
                if (!cvalid) begin
                    err_next = 1'b1;
                end else if (from_l == node_reg && !vis_reg[lidx(to_l)]) begin
                    stk_we    = 1'b1;
                    sp_next   = sp_reg + 1'b1;
                    node_next = to_l;
                    edge_next = '0;
                    vis_next[lidx(to_l)] = 1'b1;
                    if (pass_reg) begin
                        tru_next[lidx(neg_lit(to_l, n_l))] = 1'b1;
                    end
                end
            end
            ST_POP: begin
                node_next  = stk_rdata[SW-1:EW];
                edge_next  = stk_rdata[EW-1:0];
                state_next = ST_SCAN;
            end
            ST_BNEXT: begin
                if (bidx_reg == '0) begin
                    k_next     = '0;
                    cnt_next   = '0;
                    mask_next  = '0;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_BGOT;
                end
            end
            ST_BGOT: begin
                if (!vis_reg[lidx(v)] && !vis_reg[lidx(c)]) begin
                    vis_next[lidx(v)] = 1'b1;
                    tru_next[lidx(c)] = 1'b1;
                    node_next  = v;
                    edge_next  = '0;
                    sp_next    = '0;
                    state_next = ST_SCAN;
                end else begin
                    bidx_next  = bidx_reg - 1'b1;
                    state_next = ST_BNEXT;
                end
            end
            ST_OUT: begin
                if (k_reg == n_eff) begin
                    state_next = ST_SEND;
                end else begin
                    mask_next[k_reg[$clog2(MASK_W)-1:0]] = tru_reg[SAW'(k_reg)];
                    cnt_next = cnt_reg + CNT_W'(tru_reg[SAW'(k_reg)]);
                    k_next   = k_reg + 1'b1;
                end
            end
            ST_SEND: begin
                if (m_tready) begin
                    total_next = '0;
                    err_next   = 1'b0;
                    vis_next   = '0;
                    tru_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            nv_reg    <= VAR_W'(1);
            total_reg <= '0;
            err_reg   <= 1'b0;
            vis_reg   <= '0;
            tru_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                nv_reg <= cfg_wr_data;
            end
            total_reg <= total_next;
            err_reg   <= err_next;
            vis_reg   <= vis_next;
            tru_reg   <= tru_next;
            flen_reg  <= flen_next;
            sp_reg    <= sp_next;
            node_reg  <= node_next;
            edge_reg  <= edge_next;
            root_reg  <= root_next;
            bidx_reg  <= bidx_next;
            pass_reg  <= pass_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
            mask_reg  <= mask_next;
        end
    end

    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is offered");

    a_clear_after_send: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> (total_reg == '0 && !err_reg && vis_reg == '0))
        else $error("problem not cleared after the result item");

    a_node_visited: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> vis_reg[lidx(node_reg)])
        else $error("walking a literal that is not marked visited");

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Two-SAT solver testbench
// Sends clause problems over the input stream and predicts each solved
// assignment with an in-bench implication-graph solver, then checks every
// result item field by field. Directed cases come first, then random problems.
// ----------------------------------------------------------------------------
module testbench
    import tsat_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NVMAX     = 64;
    localparam int CAP       = 256;
    localparam int LITS      = 2 * NVMAX + 1;
    localparam int EDGES     = 2 * CAP;
    localparam int CYC_LIMIT = 10000000;

    typedef struct packed {
        logic             err;
        logic [MASK_W-1:0] mask;
        logic [CNT_W-1:0]  count;
    } solution_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [VAR_W-1:0]    cfg_wr_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [CLAUSE_W-1:0] s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;

    two_sat_scc_solver dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // Predictor state.
    logic [VAR_W-1:0]    vars_reg;
    clause_t             loaded_clauses[$];
    bit                  problem_err;
    solution_t           pending_solutions[$];

    int  lit_head[2][LITS];
    int  lit_tail[2][LITS];
    int  edge_to[2][EDGES];
    int  edge_next[2][EDGES];
    int  edge_cnt[2];
    bit  seen_lit[LITS];
    bit  true_lit[LITS];
    int  finish_seq[LITS];
    int  finish_len;
    int  stk_node[LITS];
    int  stk_edge[LITS];

    int  errors;
    int  cycles;
    int  items_sent;
    bit  no_gaps;
    int  rx_hold;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver: random back-pressure, or a long hold-off when asked.
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else begin
            m_tready <= (gap_len() == 0);
        end
    end

    function automatic int flip(int l, int n);
        return (l > n) ? l - n : l + n;
    endfunction

    function automatic void link(int g, int from, int to);
        int e;
        e = edge_cnt[g];
        if (e >= EDGES || from >= LITS) return;
        edge_cnt[g]     = e + 1;
        edge_to[g][e]   = to;
        edge_next[g][e] = -1;
        if (lit_head[g][from] < 0) lit_head[g][from] = e;
        else edge_next[g][lit_tail[g][from]] = e;
        lit_tail[g][from] = e;
    endfunction

    function automatic void push_lit(int g, int l, ref int sp, input int n);
        seen_lit[l] = 1'b1;
        if (g == 1) true_lit[flip(l, n)] = 1'b1;
        stk_node[sp] = l;
        stk_edge[sp] = lit_head[g][l];
        sp++;
    endfunction

    function automatic void explore(int g, int root, int n);
        int sp, node, e, t;
        sp = 0;
        push_lit(g, root, sp, n);
        while (sp > 0) begin
            node = stk_node[sp-1];
            e    = stk_edge[sp-1];
            if (e < 0) begin
                sp--;
                if (g == 0) begin
                    finish_seq[finish_len] = node;
                    finish_len++;
                end
            end else begin
                stk_edge[sp-1] = edge_next[g][e];
                t = edge_to[g][e];
                if (!seen_lit[t]) push_lit(g, t, sp, n);
            end
        end
    endfunction

    function automatic int eff_vars();
        if (vars_reg == 0) return 1;
        if (vars_reg > NVMAX) return NVMAX;
        return vars_reg;
    endfunction

    function automatic void predict_solution(clause_t c, bit last);
        int n, x, y, v;
        solution_t s;
        n = eff_vars();
        if (c.var_a < 1 || c.var_a > n || c.var_b < 1 || c.var_b > n
                || loaded_clauses.size() >= CAP)
            problem_err = 1'b1;
        else
            loaded_clauses.insert(loaded_clauses.size(), c);
        if (!last) return;
        for (int i = 0; i < LITS; i++) begin
            for (int g = 0; g < 2; g++) begin
                lit_head[g][i] = -1;
                lit_tail[g][i] = 0;
            end
        end
        edge_cnt[0] = 0;
        edge_cnt[1] = 0;
        foreach (loaded_clauses[i]) begin
            if (loaded_clauses[i].var_a > n || loaded_clauses[i].var_b > n) begin
                problem_err = 1'b1;
            end else begin
                x = loaded_clauses[i].kind[1] ? flip(loaded_clauses[i].var_a, n)
                                               : loaded_clauses[i].var_a;
                y = loaded_clauses[i].kind[0] ? flip(loaded_clauses[i].var_b, n)
                                               : loaded_clauses[i].var_b;
                link(0, flip(x, n), y);
                link(0, flip(y, n), x);
                link(1, x, flip(y, n));
                link(1, y, flip(x, n));
            end
        end
        for (int i = 0; i < LITS; i++) begin
            seen_lit[i] = 1'b0;
            true_lit[i] = 1'b0;
        end
        finish_len = 0;
        for (int l = 1; l <= 2 * n; l++)
            if (!seen_lit[l]) explore(0, l, n);
        for (int i = 0; i < LITS; i++) seen_lit[i] = 1'b0;
        for (int i = finish_len; i > 0; i--) begin
            v = finish_seq[i-1];
            if (!seen_lit[v] && !seen_lit[flip(v, n)]) explore(1, v, n);
        end
        s = '0;
        for (int l = 1; l <= n; l++) begin
            if (true_lit[l]) begin
                s.mask[l-1] = 1'b1;
                s.count     = s.count + 1'b1;
            end
        end
        s.err = problem_err;
        pending_solutions.insert(pending_solutions.size(), s);
        loaded_clauses.delete();
        problem_err = 1'b0;
    endfunction

    // Result checker.
    always @(posedge aclk) begin
        solution_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_solutions.size() == 0) begin
                $error("unexpected result item %h", m_tdata);
                errors++;
            end else begin
                want = pending_solutions.pop_front();
                if (got.count !== want.count) begin
                    $error("chosen_count: expected %0d, got %0d", want.count, got.count);
                    errors++;
                end
                if (got.mask !== want.mask) begin
                    $error("chosen_mask: expected %h, got %h", want.mask, got.mask);
                    errors++;
                end
                if (got.err !== want.err) begin
                    $error("input_error: expected %0d, got %0d", want.err, got.err);
                    errors++;
                end
            end
        end
    end

    task automatic send_clause(int a, int b, int kind, bit last);
        clause_t c;
        int gap;
        c.var_a = a[VAR_W-1:0];
        c.var_b = b[VAR_W-1:0];
        c.kind  = kind[KIND_W-1:0];
        gap = gap_len();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = c;
        s_tlast  = last;
        do @(posedge aclk); while (!s_tready);
        predict_solution(c, last);
        items_sent++;
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_solutions.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic set_vars(int v);
        settle();
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v[VAR_W-1:0];
        vars_reg    = v[VAR_W-1:0];
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic test_clause_kinds();
        set_vars(2);
        for (int k = 0; k < 4; k++) send_clause(1 + k % 2, 2 - k % 2, k, k == 3);
        set_vars(1);
        send_clause(1, 1, 0, 0);
        send_clause(1, 1, 3, 1);
    endtask

    task automatic test_extremes();
        set_vars(64);
        send_clause(64, 1, 0, 0);
        send_clause(1, 64, 3, 0);
        send_clause(64, 64, 2, 1);
        set_vars(0);
        send_clause(1, 1, 1, 1);
        set_vars(127);
        send_clause(64, 63, 0, 1);
    endtask

    task automatic test_bad_indices();
        set_vars(4);
        send_clause(0, 1, 0, 0);
        send_clause(2, 5, 1, 0);
        send_clause(127, 3, 2, 0);
        send_clause(3, 4, 0, 1);
        send_clause(1, 2, 3, 0);
        send_clause(0, 2, 0, 1);
    endtask

    task automatic test_shrunk_vars();
        set_vars(8);
        send_clause(8, 7, 0, 0);
        send_clause(2, 3, 2, 0);
        set_vars(4);
        send_clause(1, 2, 1, 1);
    endtask

    task automatic test_store_full();
        set_vars(4);
        no_gaps = 1'b1;
        for (int i = 0; i < CAP + 3; i++)
            send_clause($urandom_range(1, 4), $urandom_range(1, 4),
                        $urandom_range(0, 3), i == CAP + 2);
        no_gaps = 1'b0;
    endtask

    task automatic test_output_stall();
        set_vars(5);
        @(posedge aclk);
        rx_hold = 2000;
        for (int p = 0; p < 3; p++)
            for (int i = 0; i < 4; i++)
                send_clause($urandom_range(1, 5), $urandom_range(1, 5),
                            $urandom_range(0, 3), i == 3);
        settle();
    endtask

    task automatic test_random(int target);
        int n, len, a, b;
        while (items_sent < target) begin
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 9))
                    0:       n = 64;
                    1:       n = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
                    default: n = $urandom_range(1, 12);
                endcase
                set_vars(n);
            end
            n = eff_vars();
            len = (n > 12) ? $urandom_range(1, 6) : $urandom_range(1, 24);
            no_gaps = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < len; i++) begin
                a = $urandom_range(1, n);
                b = $urandom_range(1, n);
                if ($urandom_range(0, 99) < 6) a = $urandom_range(0, 1) ? 0
                                               : $urandom_range(n + 1 > 127 ? 127 : n + 1, 127);
                if ($urandom_range(0, 99) < 6) b = $urandom_range(n, 127);
                send_clause(a, b, $urandom_range(0, 3), i == len - 1);
            end
            no_gaps = 1'b0;
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        vars_reg    = 1;
        problem_err = 1'b0;
        errors      = 0;
        cycles      = 0;
        items_sent  = 0;
        no_gaps     = 1'b0;
        rx_hold     = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_clause_kinds();
        test_extremes();
        test_bad_indices();
        test_shrunk_vars();
        test_store_full();
        test_output_stall();
        test_random(1150);
        settle();

        if (errors == 0 && pending_solutions.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            if (pending_solutions.size() != 0)
                $error("%0d result items never arrived", pending_solutions.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
